// ===== rtl/core/b64enc_pkg.sv =====
// ----------------------------------------------------------------------------
// b64enc_pkg
// Types, constants and the alphabet lookup shared by the Base64 encoder.
// ----------------------------------------------------------------------------
package b64enc_pkg;

  // One raw byte of a message
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } byte_item_t;

  // One encoded character
  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } char_item_t;

  // One three-byte group, zero filled, with its count of real bytes
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  count;
    logic        last;
  } group_t;

  // Positions within a group
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;

  // Real byte counts of a group
  localparam logic [1:0] CNT_ONE   = 2'd1;
  localparam logic [1:0] CNT_TWO   = 2'd2;
  localparam logic [1:0] CNT_THREE = 2'd3;

  // Character slots within an encoded quad
  localparam logic [1:0] SLOT_0 = 2'd0;
  localparam logic [1:0] SLOT_1 = 2'd1;
  localparam logic [1:0] SLOT_2 = 2'd2;
  localparam logic [1:0] SLOT_3 = 2'd3;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Map a sextet onto the standard alphabet
  function automatic logic [7:0] b64_char(input logic [5:0] sextet);
    logic [7:0] v;
    v = {2'b00, sextet};
    if (sextet < 6'd26) begin
      b64_char = 8'h41 + v;
    end else if (sextet < 6'd52) begin
      b64_char = 8'h61 + v - 8'd26;
    end else if (sextet < 6'd62) begin
      b64_char = 8'h30 + v - 8'd52;
    end else if (sextet == 6'd62) begin
      b64_char = 8'h2B;
    end else begin
      b64_char = 8'h2F;
    end
  endfunction

endpackage

// ===== rtl/core/b64enc_front.sv =====
// ----------------------------------------------------------------------------
// b64enc_front
// Collects incoming bytes into three-byte groups and issues each complete
// or final group to the group queue.
// ----------------------------------------------------------------------------
module b64enc_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  b64enc_pkg::byte_item_t byte_item,
  output logic                   grp_push,
  output b64enc_pkg::group_t     grp
);
  import b64enc_pkg::*;

  logic [1:0] pos;
  logic [1:0] pos_next;
  logic [7:0] pend0;
  logic [7:0] pend1;
  logic       hold;

  // Build the group; store the byte when the group is neither full nor ended, else push it
  always_comb begin
    hold     = 1'b0;
    pos_next = pos;
    grp      = '0;
    unique case (pos)
      POS_SECOND: begin
        hold     = !byte_item.end_of_message;
        grp.bits = {pend0, byte_item.data_byte, 8'h00};
        grp.count = CNT_TWO;
      end
      POS_THIRD: begin
        grp.bits = {pend0, pend1, byte_item.data_byte};
        grp.count = CNT_THREE;
      end
      default: begin
        hold     = !byte_item.end_of_message;
        grp.bits = {byte_item.data_byte, 16'h0000};
        grp.count = CNT_ONE;
      end
    endcase
    grp.last = byte_item.end_of_message;
    grp_push = take && !hold;
    if (take) begin
      pos_next = hold ? ((pos == POS_SECOND) ? POS_THIRD : POS_SECOND) : POS_FIRST;
    end
  end

  // Advance the group position
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_FIRST;
    end else begin
      pos <= pos_next;
    end
  end

  // Hold pending bytes
  always_ff @(posedge clk) begin
    if (take && hold) begin
      if (pos == POS_SECOND) begin
        pend1 <= byte_item.data_byte;
      end else begin
        pend0 <= byte_item.data_byte;
      end
    end
  end

endmodule

// ===== rtl/core/b64enc_queue.sv =====
// ----------------------------------------------------------------------------
// b64enc_queue
// Short register queue of groups between the front and back parts.
// ----------------------------------------------------------------------------
module b64enc_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  b64enc_pkg::group_t wdata,
  input  logic               pop,
  output b64enc_pkg::group_t rdata,
  output logic               full,
  output logic               empty
);
  import b64enc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  group_t        slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign full  = (fill == CW'(DEPTH));
  assign empty = (fill == '0);
  assign rdata = slots[rd_ptr];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Write the incoming group
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== rtl/core/b64enc_back.sv =====
// ----------------------------------------------------------------------------
// b64enc_back
// Takes groups from the queue and hands out their four characters, one
// beat per cycle while pop is held, with padding and the end-of-message flag.
// ----------------------------------------------------------------------------
module b64enc_back (
  input  logic                   clk,
  input  logic                   rst,
  input  b64enc_pkg::group_t     grp,
  input  logic                   grp_avail,
  output logic                   grp_take,
  input  logic                   pop,
  output logic                   empty,
  output b64enc_pkg::char_item_t char_item
);
  import b64enc_pkg::*;

  group_t     cur;
  logic       busy;
  logic [1:0] slot;
  logic       done;
  logic [5:0] sextet;
  logic       pad;

  assign empty    = !busy;
  assign done     = busy && pop && (slot == SLOT_3);
  assign grp_take = grp_avail && (!busy || done);

  // Pick the sextet and decide padding for the current slot
  always_comb begin
    unique case (slot)
      SLOT_0:  begin sextet = cur.bits[23:18]; pad = 1'b0; end
      SLOT_1:  begin sextet = cur.bits[17:12]; pad = 1'b0; end
      SLOT_2:  begin sextet = cur.bits[11:6];  pad = (cur.count == CNT_ONE); end
      default: begin sextet = cur.bits[5:0];   pad = (cur.count != CNT_THREE); end
    endcase
    char_item.out_char  = pad ? PAD_CHAR : b64_char(sextet);
    char_item.last_char = cur.last && (slot == SLOT_3);
  end

  // Advance through the quad, load the next group when idle or at its end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= SLOT_0;
    end else if (grp_take) begin
      busy <= 1'b1;
      slot <= SLOT_0;
    end else if (done) begin
      busy <= 1'b0;
      slot <= SLOT_0;
    end else if (busy && pop) begin
      slot <= slot + 1'b1;
    end
  end

  // Hold the group being emitted
  always_ff @(posedge clk) begin
    if (grp_take) begin
      cur <= grp;
    end
  end

endmodule

// ===== rtl/core/base64_stream_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// base64_stream_encoder_unit
// Streaming Base64 encoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
//  channel   | ports                     | beat
//  ----------+---------------------------+-----------------------------------
//  bytes     | push, full, byte_item     | push & !full, one raw byte
//  chars     | pop, empty, char_item     | pop & !empty, one ASCII character
//
// A byte is taken every cycle while the group queue has room. Each group
// yields four characters at one per cycle from the back part while pop is
// held. The last byte of a group is written into the queue, and once the
// back part is free the group is loaded into it before its first character
// is on the result ports. Reset clears the group position, the queue and
// the back part. Stalls on pop back up into the queue and then raise full.
module base64_stream_encoder_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  b64enc_pkg::byte_item_t byte_item,
  output logic                   empty,
  input  logic                   pop,
  output b64enc_pkg::char_item_t char_item
);
  import b64enc_pkg::*;

  logic   take;
  logic   grp_push;
  group_t grp_in;
  group_t grp_out;
  logic   q_empty;
  logic   grp_take;

  assign take = push && !full;

  b64enc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .byte_item (byte_item),
    .grp_push  (grp_push),
    .grp       (grp_in)
  );

  b64enc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (grp_push),
    .wdata (grp_in),
    .pop   (grp_take),
    .rdata (grp_out),
    .full  (full),
    .empty (q_empty)
  );

  b64enc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .grp       (grp_out),
    .grp_avail (!q_empty),
    .grp_take  (grp_take),
    .pop       (pop),
    .empty     (empty),
    .char_item (char_item)
  );

endmodule

// ===== rtl/core/b64enc_checker.sv =====
// ----------------------------------------------------------------------------
// b64enc_checker
// Port-level checks on the Base64 encoder, bound to the top level.
// ----------------------------------------------------------------------------
module b64enc_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   push,
  input logic                   full,
  input b64enc_pkg::byte_item_t byte_item,
  input logic                   empty,
  input logic                   pop,
  input b64enc_pkg::char_item_t char_item
);
  import b64enc_pkg::*;

  // Reset leaves both sides idle
  a_reset_idle: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("encoder not idle after reset");

  // A stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(char_item))
    else $error("stalled character changed");

  // Padding at a non-final slot is followed at once by more padding
  a_pad_pair: assert property (@(posedge clk) disable iff (rst)
    !empty && pop && char_item.out_char == PAD_CHAR && !char_item.last_char
      |=> !empty && char_item.out_char == PAD_CHAR && char_item.last_char)
    else $error("lone padding character");

  // A full queue means the back part is busy
  a_full_busy: assert property (@(posedge clk) disable iff (rst)
    full |-> !empty)
    else $error("queue full while output idle");

endmodule

bind base64_stream_encoder_unit b64enc_checker u_b64enc_checker (
  .clk       (clk),
  .rst       (rst),
  .push      (push),
  .full      (full),
  .byte_item (byte_item),
  .empty     (empty),
  .pop       (pop),
  .char_item (char_item)
);
